// ----- src/dlct_pkg.sv -----
// shared types and constants for the delta-list callout timer
// no dependencies; imported by dlct_cell, dlct_ctrl and the top level
`default_nettype none

package dlct_pkg;

    localparam int DLCT_DEPTH = 16;
    localparam int DLCT_FIELD_W = 16;
    localparam int DLCT_DELAY_W = 15;

    localparam logic CMD_TICK = 1'b0;
    localparam logic CMD_INSERT = 1'b1;

    typedef enum logic [1:0] {
        KIND_INSERT_OK = 2'd0,
        KIND_INSERT_FULL = 2'd1,
        KIND_TICK_IDLE = 2'd2,
        KIND_FIRED = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PASS,
        ST_ROTATE
    } state_t;

    typedef struct packed {
        logic [DLCT_FIELD_W-1:0] delta;
        logic [DLCT_FIELD_W-1:0] handle;
        logic [DLCT_FIELD_W-1:0] argument;
    } entry_t;

endpackage

`default_nettype wire

// ----- src/dlct_cell.sv -----
// one table slot of the callout ring: holds an entry, takes its neighbor's on shift
// depends on dlct_pkg
`default_nettype none

module dlct_cell
    import dlct_pkg::*;
(
    input  wire    clk,
    input  wire    shift_en,
    input  entry_t d,
    output entry_t q
);

    entry_t entry_reg;
    entry_t entry_next;

    always_comb
    begin
        entry_next = shift_en ? d : entry_reg;
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign q = entry_reg;

endmodule

`default_nettype wire

// ----- src/dlct_ctrl.sv -----
// sequencer and head unit: takes each entry off the ring head, edits it, feeds the tail
// depends on dlct_pkg
`default_nettype none

module dlct_ctrl
    import dlct_pkg::*;
#(
    parameter int TABLE_DEPTH = DLCT_DEPTH
)
(
    input  wire                     clk,
    input  wire                     rst_n,
    input  wire                     start,
    input  wire                     cmd,
    input  wire                     deferred,
    input  wire  [DLCT_FIELD_W-1:0] handle,
    input  wire  [DLCT_FIELD_W-1:0] argument,
    input  wire  [DLCT_DELAY_W-1:0] delay,
    input  entry_t                  head,
    output entry_t                  tail,
    output logic                    shift_en,
    output logic                    busy,
    output logic                    done,
    output logic [1:0]              kind,
    output logic [DLCT_FIELD_W-1:0] fired_handle,
    output logic [DLCT_FIELD_W-1:0] fired_argument,
    output logic                    last
);

    localparam int CW = $clog2(TABLE_DEPTH);
    localparam logic [CW-1:0] LAST_CYC = CW'(TABLE_DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(TABLE_DEPTH - 1);

    state_t state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] cyc_reg, cyc_next;
    logic [CW-1:0] fire_cnt_reg, fire_cnt_next;
    logic cmd_reg, cmd_next;
    logic walking_reg, walking_next;
    logic found_reg, found_next;
    logic firing_reg, firing_next;
    logic pend_valid_reg, pend_valid_next;
    entry_t pend_reg, pend_next;
    entry_t carry_reg, carry_next;
    logic [DLCT_FIELD_W-1:0] new_handle_reg, new_handle_next;
    logic [DLCT_FIELD_W-1:0] new_arg_reg, new_arg_next;
    logic signed [DLCT_FIELD_W:0] t_reg, t_next;

    logic done_reg, done_next;
    kind_t kind_reg, kind_next;
    logic [DLCT_FIELD_W-1:0] fh_reg, fh_next;
    logic [DLCT_FIELD_W-1:0] fa_reg, fa_next;
    logic last_reg, last_next;

    logic reject;
    logic last_cyc;
    logic live;
    logic signed [DLCT_FIELD_W:0] dh;
    logic signed [DLCT_FIELD_W:0] dh_dec;
    logic dec;
    logic fire;

    assign reject = ((cmd == CMD_INSERT) && (count_reg == FULL_CNT))
                 || ((cmd == CMD_TICK) && (count_reg == '0));
    assign last_cyc = (cyc_reg == LAST_CYC);
    assign live = (cyc_reg < count_reg);
    assign dh = $signed({head.delta[DLCT_FIELD_W-1], head.delta});
    assign dec = !found_reg && live && (dh > 0);
    assign dh_dec = dec ? (dh - 17'sd1) : dh;
    assign fire = firing_reg && live && (dh_dec <= 0);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start && !reject)
                begin
                    state_next = ST_PASS;
                end
            end
            ST_PASS:
            begin
                if (last_cyc)
                begin
                    state_next = (fire_cnt_reg != '0) ? ST_ROTATE : ST_IDLE;
                end
            end
            ST_ROTATE:
            begin
                if (fire_cnt_reg == CW'(1))
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // datapath and results
    always_comb
    begin
        count_next = count_reg;
        cyc_next = cyc_reg;
        fire_cnt_next = fire_cnt_reg;
        cmd_next = cmd_reg;
        walking_next = walking_reg;
        found_next = found_reg;
        firing_next = firing_reg;
        pend_valid_next = pend_valid_reg;
        pend_next = pend_reg;
        carry_next = carry_reg;
        new_handle_next = new_handle_reg;
        new_arg_next = new_arg_reg;
        t_next = t_reg;
        done_next = 1'b0;
        kind_next = KIND_TICK_IDLE;
        fh_next = '0;
        fa_next = '0;
        last_next = 1'b0;
        shift_en = 1'b0;
        tail = head;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    if (reject)
                    begin
                        done_next = 1'b1;
                        kind_next = (cmd == CMD_INSERT) ? KIND_INSERT_FULL : KIND_TICK_IDLE;
                        last_next = 1'b1;
                    end
                    else
                    begin
                        cmd_next = cmd;
                        cyc_next = '0;
                        fire_cnt_next = '0;
                        walking_next = 1'b1;
                        found_next = 1'b0;
                        firing_next = !deferred;
                        pend_valid_next = 1'b0;
                        new_handle_next = handle;
                        new_arg_next = argument;
                        t_next = $signed({2'b00, delay});
                    end
                end
            end
            ST_PASS:
            begin
                shift_en = 1'b1;
                cyc_next = cyc_reg + CW'(1);
                if (cmd_reg == CMD_INSERT)
                begin
                    if (walking_reg)
                    begin
                        if (live && (dh <= t_reg))
                        begin
                            t_next = t_reg - dh;
                        end
                        else
                        begin
                            // new entry goes here, the displaced one waits in carry
                            tail = '{delta: t_reg[DLCT_FIELD_W-1:0],
                                     handle: new_handle_reg,
                                     argument: new_arg_reg};
                            carry_next = head;
                            carry_next.delta = 16'(dh - t_reg);
                            walking_next = 1'b0;
                        end
                    end
                    else
                    begin
                        tail = carry_reg;
                        carry_next = head;
                    end
                    if (last_cyc)
                    begin
                        done_next = 1'b1;
                        kind_next = KIND_INSERT_OK;
                        last_next = 1'b1;
                        count_next = count_reg + CW'(1);
                    end
                end
                else
                begin
                    tail.delta = dh_dec[DLCT_FIELD_W-1:0];
                    found_next = found_reg || dec;
                    if (fire)
                    begin
                        fire_cnt_next = fire_cnt_reg + CW'(1);
                        pend_valid_next = 1'b1;
                        pend_next = head;
                    end
                    else
                    begin
                        firing_next = 1'b0;
                        pend_valid_next = 1'b0;
                    end
                    // a fired item waits in pend until it is known whether it is last
                    if (pend_valid_reg)
                    begin
                        done_next = 1'b1;
                        kind_next = KIND_FIRED;
                        fh_next = pend_reg.handle;
                        fa_next = pend_reg.argument;
                        last_next = !fire;
                    end
                    if (last_cyc)
                    begin
                        if (fire_cnt_reg == '0)
                        begin
                            done_next = 1'b1;
                            kind_next = KIND_TICK_IDLE;
                            last_next = 1'b1;
                        end
                        count_next = count_reg - fire_cnt_reg;
                    end
                end
            end
            ST_ROTATE:
            begin
                // fired entries leave the front; rotating by their number compacts the table
                shift_en = 1'b1;
                fire_cnt_next = fire_cnt_reg - CW'(1);
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            cyc_reg <= '0;
            fire_cnt_reg <= '0;
            walking_reg <= 1'b0;
            found_reg <= 1'b0;
            firing_reg <= 1'b0;
            pend_valid_reg <= 1'b0;
            done_reg <= 1'b0;
            cmd_reg <= CMD_TICK;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            cyc_reg <= cyc_next;
            fire_cnt_reg <= fire_cnt_next;
            walking_reg <= walking_next;
            found_reg <= found_next;
            firing_reg <= firing_next;
            pend_valid_reg <= pend_valid_next;
            done_reg <= done_next;
            cmd_reg <= cmd_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_reg <= pend_next;
        carry_reg <= carry_next;
        new_handle_reg <= new_handle_next;
        new_arg_reg <= new_arg_next;
        t_reg <= t_next;
        kind_reg <= kind_next;
        fh_reg <= fh_next;
        fa_reg <= fa_next;
        last_reg <= last_next;
    end

    assign busy = (state_reg != ST_IDLE);
    assign done = done_reg;
    assign kind = kind_reg;
    assign fired_handle = fh_reg;
    assign fired_argument = fa_reg;
    assign last = last_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_CNT)
        else $error("entry count above table capacity");

    a_rotate_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ROTATE) |-> (fire_cnt_reg != '0))
        else $error("compaction with nothing fired");

    a_reject_reply: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE && start && reject) |=> (done && last && !busy))
        else $error("rejected item got no immediate reply");

    a_fired_payload: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (kind_reg != KIND_FIRED)) |-> (fh_reg == '0 && fa_reg == '0))
        else $error("payload set on a non-fire result");

    a_pass_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_PASS && last_cyc && fire_cnt_reg == '0) |=> (done && last))
        else $error("pass ended without a final result");

endmodule

`default_nettype wire

// ----- src/delta_list_callout_timer_top.sv -----
// delta-list callout timer: ring of table cells plus sequencer
// depends on dlct_pkg, dlct_cell, dlct_ctrl
`default_nettype none

// A sorted callout table kept as a ring of TABLE_DEPTH cells, each entry holding its delay
// relative to the entry before it; at most TABLE_DEPTH-1 entries are live. An item is taken
// when start is high and busy is low. An insert into a full table and a tick on an empty
// table answer in the next cycle and leave busy low. Any other item makes one full turn of
// the ring through the single head unit, and then the ring is rotated by the number of
// fired entries to compact the table. Each result shows on the result ports for exactly
// one cycle with done high, and the receiver must take it then; last marks the final
// result of an item.

module delta_list_callout_timer_top
    import dlct_pkg::*;
#(
    parameter int TABLE_DEPTH = DLCT_DEPTH
)
(
    input  wire                     clk,
    input  wire                     rst_n,
    input  wire                     start,
    output logic                    busy,
    input  wire                     cmd,
    input  wire                     deferred,
    input  wire  [DLCT_FIELD_W-1:0] handle,
    input  wire  [DLCT_FIELD_W-1:0] argument,
    input  wire  [DLCT_DELAY_W-1:0] delay,
    output logic                    done,
    output logic [1:0]              kind,
    output logic [DLCT_FIELD_W-1:0] fired_handle,
    output logic [DLCT_FIELD_W-1:0] fired_argument,
    output logic                    last
);

    entry_t ring [TABLE_DEPTH];
    entry_t tail;
    logic shift_en;

    // cell k takes cell k+1; the last cell takes what the head unit returns
    for (genvar k = 0; k < TABLE_DEPTH; k++)
    begin : g_cell
        if (k == TABLE_DEPTH - 1)
        begin : g_end
            dlct_cell u_cell (
                .clk      (clk),
                .shift_en (shift_en),
                .d        (tail),
                .q        (ring[k])
            );
        end
        else
        begin : g_mid
            dlct_cell u_cell (
                .clk      (clk),
                .shift_en (shift_en),
                .d        (ring[k+1]),
                .q        (ring[k])
            );
        end
    end

    dlct_ctrl #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_ctrl (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .cmd            (cmd),
        .deferred       (deferred),
        .handle         (handle),
        .argument       (argument),
        .delay          (delay),
        .head           (ring[0]),
        .tail           (tail),
        .shift_en       (shift_en),
        .busy           (busy),
        .done           (done),
        .kind           (kind),
        .fired_handle   (fired_handle),
        .fired_argument (fired_argument),
        .last           (last)
    );

endmodule

`default_nettype wire
